>>> design/gbsp_pkg.sv
// Package for the greedy balanced slice partitioner.
// Holds field widths, default parameter values and configuration register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbsp_pkg;

    localparam int COUNT_WIDTH_DEF = 40;
    localparam int INDEX_WIDTH_DEF = 32;

    localparam int NNZ_WIDTH       = 40;
    localparam int PARTS_WIDTH     = 16;
    localparam int SLICE_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 40;

    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 2 * SLICE_WIDTH;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TARGET_PER_PART = 2'd0,
        REG_NUM_PARTS       = 2'd1,
        REG_MY_PART         = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [SLICE_WIDTH-1:0] part_end;
        logic [SLICE_WIDTH-1:0] part_start;
        logic                   too_many_parts;
    } t_result;

endpackage

`default_nettype wire

>>> design/greedy_balanced_slice_partitioner_top.sv
// Top level of the greedy balanced slice partitioner.
// Depends on gbsp_pkg; the checker in gbsp_checker.sv binds to it.
// Input beats carry one slice count; a result beat leaves after the beat marked tlast.
`timescale 1ns / 1ps
`default_nettype none

// Takes one slice nonzero count per cycle while tready is high, one beat per slice, in slice
// order, with tlast on the final slice of a mode. Each slice updates the state (one threshold
// add and compare, three wrapped differences, the boundary select and the running-total add),
// so the sustained rate is one beat per clock while the skid register is empty. The beat with
// tlast yields one result beat in the output register, or first in the skid register behind
// it, which keeps the input side open for one more result while the output side stalls:
// part_start in tdata[31:0], part_end in tdata[63:32] and the too-many-parts flag in tuser.
// The user must make configuration writes between modes; the block does not enforce it.
module greedy_balanced_slice_partitioner_top #(
    parameter int COUNT_WIDTH = gbsp_pkg::COUNT_WIDTH_DEF,
    parameter int INDEX_WIDTH = gbsp_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // [39:0] slice_nnz
    input  wire logic [gbsp_pkg::IN_TDATA_WIDTH-1:0]   i_s_tdata,
    input  wire logic                                  i_s_tlast,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // [31:0] part_start, [63:32] part_end
    output logic [gbsp_pkg::OUT_TDATA_WIDTH-1:0]       o_m_tdata,
    // [0] too_many_parts
    output logic                                       o_m_tuser,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [gbsp_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [gbsp_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int PW = gbsp_pkg::PARTS_WIDTH;

    logic [gbsp_pkg::NNZ_WIDTH-1:0] r_target;
    logic [PW-1:0]                  r_num_parts;
    logic [PW-1:0]                  r_my_part;

    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic [COUNT_WIDTH-1:0] r_base, n_base;
    logic [COUNT_WIDTH-1:0] r_prev, n_prev;
    logic [PW-1:0]          r_closed, n_closed;
    logic [INDEX_WIDTH-1:0] r_slice, n_slice;
    logic [INDEX_WIDTH-1:0] r_start, n_start;
    logic [INDEX_WIDTH-1:0] r_end, n_end;
    logic                   r_end_found, n_end_found;

    gbsp_pkg::t_result r_out, r_skid, w_res;
    logic              r_out_valid, r_skid_valid;

    logic                   w_in_beat;
    logic                   w_out_free;
    logic [COUNT_WIDTH-1:0] w_cnt, w_thr, w_before, w_here_d, w_prev_d;
    logic                   w_hit;
    logic [PW-1:0]          w_closed_inc;
    logic [PW:0]            w_my_next;
    logic [INDEX_WIDTH-1:0] w_count_total, w_st, w_en;
    logic                   w_flag;
    logic [63:0]            w_st_ext, w_en_ext;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign w_in_beat   = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_num_parts <= PW'(1);
            r_my_part   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (gbsp_pkg::t_cfg_reg'(i_cfg_index))
                gbsp_pkg::REG_TARGET_PER_PART: r_target <= i_cfg_data;
                gbsp_pkg::REG_NUM_PARTS:       r_num_parts <= i_cfg_data[PW-1:0];
                gbsp_pkg::REG_MY_PART:         r_my_part <= i_cfg_data[PW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cnt        = COUNT_WIDTH'(i_s_tdata[gbsp_pkg::NNZ_WIDTH-1:0]);
        w_thr        = r_base + COUNT_WIDTH'(r_target);
        w_before     = r_total - r_prev;
        w_here_d     = r_total - w_thr;
        w_prev_d     = w_thr - w_before;
        w_hit        = !r_end_found && (r_total >= w_thr);
        w_closed_inc = r_closed + PW'(1);
        w_my_next    = {1'b0, r_my_part} + (PW+1)'(1);

        n_base      = r_base;
        n_closed    = r_closed;
        n_start     = r_start;
        n_end       = r_end;
        n_end_found = r_end_found;
        n_total     = r_total;
        n_prev      = r_prev;

        if (w_hit) begin
            if ((r_slice != '0) && (w_prev_d < w_here_d)) begin
                n_base = w_before;
            end else begin
                n_base = r_total;
            end
            n_closed = w_closed_inc;
            if (w_closed_inc == r_my_part) begin
                n_start = r_slice;
            end else if (({1'b0, w_closed_inc} == w_my_next)
                         && (w_closed_inc != r_num_parts)) begin
                n_end       = r_slice;
                n_end_found = 1'b1;
            end
        end
        if (!n_end_found) begin
            n_total = r_total + w_cnt;
            n_prev  = w_cnt;
        end
        n_slice = r_slice + INDEX_WIDTH'(1);

        w_count_total = n_slice;
        w_st          = n_start;
        w_en          = n_end_found ? n_end : w_count_total;
        w_flag        = (r_num_parts > PW'(1)) && (w_st == '0) && (w_en == w_count_total);
        if (w_flag) begin
            w_st = w_count_total;
            w_en = w_count_total;
        end
        w_st_ext = 64'(w_st);
        w_en_ext = 64'(w_en);
        w_res.part_start     = w_st_ext[gbsp_pkg::SLICE_WIDTH-1:0];
        w_res.part_end       = w_en_ext[gbsp_pkg::SLICE_WIDTH-1:0];
        w_res.too_many_parts = w_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_base      <= '0;
            r_prev      <= '0;
            r_closed    <= '0;
            r_slice     <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_end_found <= 1'b0;
        end else if (w_in_beat) begin
            if (i_s_tlast) begin
                r_total     <= '0;
                r_base      <= '0;
                r_prev      <= '0;
                r_closed    <= '0;
                r_slice     <= '0;
                r_start     <= '0;
                r_end       <= '0;
                r_end_found <= 1'b0;
            end else begin
                r_total     <= n_total;
                r_base      <= n_base;
                r_prev      <= n_prev;
                r_closed    <= n_closed;
                r_slice     <= n_slice;
                r_start     <= n_start;
                r_end       <= n_end;
                r_end_found <= n_end_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_beat && i_s_tlast;
            end
        end else if (w_in_beat && i_s_tlast) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_beat && i_s_tlast) begin
                r_out <= w_res;
            end
        end else if (w_in_beat && i_s_tlast) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.part_end, r_out.part_start};
    assign o_m_tuser  = r_out.too_many_parts;

endmodule

`default_nettype wire

>>> design/gbsp_checker.sv
// Port-level checker for the greedy balanced slice partitioner, bound to the top level.
// Depends on gbsp_pkg and greedy_balanced_slice_partitioner_top.
`timescale 1ns / 1ps
`default_nettype none

module gbsp_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_s_tvalid,
    input wire logic                                 o_s_tready,
    input wire logic                                 i_s_tlast,
    input wire logic                                 o_m_tvalid,
    input wire logic                                 i_m_tready,
    input wire logic [gbsp_pkg::OUT_TDATA_WIDTH-1:0] o_m_tdata,
    input wire logic                                 o_m_tuser
);

    localparam int SW = gbsp_pkg::SLICE_WIDTH;

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result beat changed while stalled");

    a_flag_empty_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[SW-1:0] == o_m_tdata[2*SW-1:SW]))
        else $error("too_many_parts set on a non-empty range");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && i_s_tvalid && o_s_tready && i_s_tlast)
        |=> (!o_s_tready && o_m_tvalid))
        else $error("second result not held behind a stalled output");

endmodule

bind greedy_balanced_slice_partitioner_top gbsp_checker u_gbsp_checker (.*);

`default_nettype wire
